/* rtl/gmcmf_pkg.sv */
// Shared constants for the global minimum cut block.
// No dependencies; imported by global_min_cut_max_flow.
package gmcmf_pkg;

  // Item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CUT  = 1'b1;

  // Result and register widths
  localparam int unsigned CUT_BITS = 20;
  localparam int unsigned VC_BITS  = 5;
  localparam int unsigned ROW_BITS = 4;
  localparam int unsigned WT_BITS  = 16;

  localparam logic [CUT_BITS-1:0] CUT_MAX = '1;

endpackage

/* rtl/global_min_cut_max_flow.sv */
// Global minimum cut by Edmonds-Karp max flow over all vertex pairs.
// Depends on gmcmf_pkg; capacity and residual matrices live in internal memories.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  item in | operation_i row_i col_i weight_i        | start_i while busy_o low
//  result  | min_cut_o no_pair_o                     | done_o, one cycle, no stall
//  config  | cfg_wdata_i                             | cfg_we_i, written at once
//
// After reset a clearing pass walks the capacity memory, one entry a cycle, with
// busy_o high. An edge load writes (row, col) when accepted, then (col, row) in
// S_LOAD2, one per matrix direction on the single write port.
// A compute item copies the capacity memory into the residual memory for each pair
// (one entry a cycle), then runs breadth-first searches (S_BRD read, S_BCHK check)
// and path walks (S_PPAR, S_PWAIT, S_PFWD, S_PREV); the total depends on the graph.
// Results cannot be stalled; done_o pulses for exactly one cycle.
module global_min_cut_max_flow #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              operation_i,
  input  logic [gmcmf_pkg::ROW_BITS-1:0]    row_i,
  input  logic [gmcmf_pkg::ROW_BITS-1:0]    col_i,
  input  logic [gmcmf_pkg::WT_BITS-1:0]     weight_i,
  input  logic                              cfg_we_i,
  input  logic [gmcmf_pkg::VC_BITS-1:0]     cfg_wdata_i,
  output logic                              done_o,
  output logic [gmcmf_pkg::CUT_BITS-1:0]    min_cut_o,
  output logic                              no_pair_o
);
  import gmcmf_pkg::*;

  localparam int unsigned VW    = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned AW    = 2 * VW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned RW    = WEIGHT_BITS + 1;
  localparam int unsigned FW    = WEIGHT_BITS + VW + 1;

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_LOAD2 = 15'b000000000000100,
    S_COPY  = 15'b000000000001000,
    S_BINIT = 15'b000000000010000,
    S_BPOP  = 15'b000000000100000,
    S_BU    = 15'b000000001000000,
    S_BRD   = 15'b000000010000000,
    S_BCHK  = 15'b000000100000000,
    S_PPAR  = 15'b000001000000000,
    S_PWAIT = 15'b000010000000000,
    S_PFWD  = 15'b000100000000000,
    S_PREV  = 15'b001000000000000,
    S_PAIR  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q;

  // Control registers
  logic [VC_BITS-1:0]   vc_q;
  logic [AW-1:0]        clr_cnt_q;
  logic [AW:0]          cp_cnt_q;
  logic                 cp_vld_q;
  logic [AW-1:0]        cp_addr_q;
  logic [AW-1:0]        ld_addr_q;
  logic [WEIGHT_BITS-1:0] ld_w_q;
  logic [VW-1:0]        s_q, t_q, u_q, v_q, w_q, p_q;
  logic [VW:0]          head_q, tail_q;
  logic [MAX_VERTICES-1:0] seen_q;
  logic                 phase_q;
  logic [RW-1:0]        neck_q;
  logic [FW-1:0]        flow_q, best_q;
  logic                 done_q, no_pair_q;
  logic [CUT_BITS-1:0]  min_cut_q;

  // Memories
  logic [WEIGHT_BITS-1:0] cap_mem [DEPTH];
  logic [RW-1:0]          res_mem [DEPTH];
  logic [VW-1:0]          par_mem [MAX_VERTICES];
  logic [VW-1:0]          que_mem [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] cap_rd_q;
  logic [RW-1:0]          res_rd_q;
  logic [VW-1:0]          par_rd_q, que_rd_q;

  logic                   cap_we;
  logic [AW-1:0]          cap_wa;
  logic [WEIGHT_BITS-1:0] cap_wd;
  logic                   res_we;
  logic [AW-1:0]          res_wa, res_ra;
  logic [RW-1:0]          res_wd;
  logic                   par_we, que_we;
  logic [VW-1:0]          que_wa, que_wd, que_ra;

  // Derived item values
  logic [7:0]             nv_wide;
  logic [VW:0]            nv;
  logic                   ld_ok;
  logic [VW-1:0]          ld_r, ld_c;
  logic [WEIGHT_BITS-1:0] ld_w;
  logic                   accept;
  logic                   found;

  assign nv_wide = ({3'b0, vc_q} > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES) : {3'b0, vc_q};
  assign nv      = nv_wide[VW:0];
  assign ld_ok   = (8'(row_i) < 8'(MAX_VERTICES)) && (8'(col_i) < 8'(MAX_VERTICES));
  assign ld_r    = VW'(row_i);
  assign ld_c    = VW'(col_i);
  assign ld_w    = WEIGHT_BITS'(weight_i);
  assign accept  = start_i && (state_q == S_IDLE);
  assign found   = !seen_q[v_q] && (res_rd_q != '0);

  // Capacity memory port control
  always_comb begin
    cap_we = 1'b0;
    cap_wa = clr_cnt_q;
    cap_wd = '0;
    if (state_q == S_CLEAR) begin
      cap_we = 1'b1;
    end else if (accept && operation_i == OP_LOAD && ld_ok) begin
      cap_we = 1'b1;
      cap_wa = {ld_r, ld_c};
      cap_wd = ld_w;
    end else if (state_q == S_LOAD2) begin
      cap_we = 1'b1;
      cap_wa = ld_addr_q;
      cap_wd = ld_w_q;
    end
  end

  // Residual memory port control
  always_comb begin
    res_we = 1'b0;
    res_wa = cp_addr_q;
    res_wd = RW'(cap_rd_q);
    res_ra = {u_q, v_q};
    unique case (state_q)
      S_COPY: res_we = cp_vld_q;
      S_PWAIT: res_ra = {par_rd_q, w_q};
      S_PFWD: begin
        res_we = phase_q;
        res_wa = {p_q, w_q};
        res_wd = res_rd_q - neck_q;
        res_ra = {w_q, p_q};
      end
      S_PREV: begin
        res_we = 1'b1;
        res_wa = {w_q, p_q};
        res_wd = res_rd_q + neck_q;
      end
      default: res_we = 1'b0;
    endcase
  end

  // Parent and queue port control
  assign par_we = (state_q == S_BCHK) && found;
  assign que_we = (state_q == S_BINIT) ||
                  ((state_q == S_BCHK) && found && (v_q != t_q) &&
                   (tail_q < (VW+1)'(MAX_VERTICES)));
  assign que_wa = (state_q == S_BINIT) ? '0 : tail_q[VW-1:0];
  assign que_wd = (state_q == S_BINIT) ? s_q : v_q;
  assign que_ra = head_q[VW-1:0];

  // Memory arrays with registered reads
  always_ff @(posedge clk_i) begin
    if (cap_we) cap_mem[cap_wa] <= cap_wd;
    cap_rd_q <= cap_mem[cp_cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_q <= res_mem[res_ra];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[v_q] <= u_q;
    par_rd_q <= par_mem[w_q];
  end

  always_ff @(posedge clk_i) begin
    if (que_we) que_mem[que_wa] <= que_wd;
    que_rd_q <= que_mem[que_ra];
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_BITS'(16);
    end else if (cfg_we_i) begin
      vc_q <= cfg_wdata_i;
    end
  end

  // Pulse done for one cycle when a result leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_DONE) ||
                (accept && (operation_i == OP_CUT) && (nv < (VW+1)'(2)));
    end
  end

  // Sequencer: clear, load, per-pair copy, search and augment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      cp_cnt_q  <= '0;
      cp_vld_q  <= 1'b0;
      cp_addr_q <= '0;
      ld_addr_q <= '0;
      ld_w_q    <= '0;
      s_q       <= '0;
      t_q       <= '0;
      u_q       <= '0;
      v_q       <= '0;
      w_q       <= '0;
      p_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      seen_q    <= '0;
      phase_q   <= 1'b0;
      neck_q    <= '1;
      flow_q    <= '0;
      best_q    <= '1;
      no_pair_q <= 1'b0;
      min_cut_q <= '0;
    end else begin
      cp_vld_q  <= (state_q == S_COPY) && (cp_cnt_q < (AW+1)'(DEPTH));
      cp_addr_q <= cp_cnt_q[AW-1:0];
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            if (operation_i == OP_LOAD) begin
              ld_addr_q <= {ld_c, ld_r};
              ld_w_q    <= ld_w;
              if (ld_ok) state_q <= S_LOAD2;
            end else if (nv < (VW+1)'(2)) begin
              no_pair_q <= 1'b1;
              min_cut_q <= '0;
            end else begin
              best_q   <= '1;
              s_q      <= '0;
              t_q      <= VW'(1);
              cp_cnt_q <= '0;
              flow_q   <= '0;
              state_q  <= S_COPY;
            end
          end
        end
        S_LOAD2: state_q <= S_IDLE;
        S_COPY: begin
          if (cp_cnt_q == (AW+1)'(DEPTH)) begin
            state_q <= S_BINIT;
          end else begin
            cp_cnt_q <= cp_cnt_q + 1'b1;
          end
        end
        S_BINIT: begin
          seen_q        <= MAX_VERTICES'(1) << s_q;
          head_q        <= '0;
          tail_q        <= (VW+1)'(1);
          state_q       <= S_BPOP;
        end
        S_BPOP: begin
          if (head_q == tail_q) begin
            state_q <= S_PAIR;
          end else begin
            head_q  <= head_q + 1'b1;
            state_q <= S_BU;
          end
        end
        S_BU: begin
          u_q     <= que_rd_q;
          v_q     <= '0;
          state_q <= S_BRD;
        end
        S_BRD: state_q <= S_BCHK;
        S_BCHK: begin
          if (found) seen_q[v_q] <= 1'b1;
          if (found && v_q == t_q) begin
            w_q     <= t_q;
            neck_q  <= '1;
            phase_q <= 1'b0;
            state_q <= S_PPAR;
          end else begin
            if (que_we) tail_q <= tail_q + 1'b1;
            if (({1'b0, v_q} + 1'b1) == nv) begin
              state_q <= S_BPOP;
            end else begin
              v_q     <= v_q + 1'b1;
              state_q <= S_BRD;
            end
          end
        end
        S_PPAR: begin
          if (w_q == s_q) begin
            if (!phase_q) begin
              phase_q <= 1'b1;
              w_q     <= t_q;
            end else begin
              flow_q  <= flow_q + FW'(neck_q);
              state_q <= S_BINIT;
            end
          end else begin
            state_q <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          p_q     <= par_rd_q;
          state_q <= S_PFWD;
        end
        S_PFWD: begin
          if (!phase_q) begin
            if (res_rd_q < neck_q) neck_q <= res_rd_q;
            w_q     <= p_q;
            state_q <= S_PPAR;
          end else begin
            state_q <= S_PREV;
          end
        end
        S_PREV: begin
          w_q     <= p_q;
          state_q <= S_PPAR;
        end
        S_PAIR: begin
          if (flow_q < best_q) best_q <= flow_q;
          cp_cnt_q <= '0;
          flow_q   <= '0;
          if (({1'b0, t_q} + 1'b1) < nv) begin
            t_q     <= t_q + 1'b1;
            state_q <= S_COPY;
          end else if (({1'b0, s_q} + (VW+1)'(2)) < nv) begin
            s_q     <= s_q + 1'b1;
            t_q     <= s_q + VW'(2);
            state_q <= S_COPY;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          no_pair_q <= 1'b0;
          min_cut_q <= (64'(best_q) > 64'(CUT_MAX)) ? CUT_MAX : CUT_BITS'(best_q);
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign min_cut_o = min_cut_q;
  assign no_pair_o = no_pair_q;

  // Checks
  a_nopair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_pair_o) |-> (min_cut_o == '0))
    else $error("no_pair result with nonzero cut");

  a_cut_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !no_pair_o) |-> $past(state_q == S_DONE))
    else $error("cut result without finishing the pair sweep");

  a_chk_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BCHK) |-> $past(state_q == S_BRD))
    else $error("search check without a residual read");

  a_rev_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREV) |-> ($past(state_q == S_PFWD) && phase_q))
    else $error("reverse update outside the update walk");

endmodule
